### hdl/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg: shared definitions for the graph reachability block
// action codes, field widths and register defaults
// ----------------------------------------------------------------------------
package grd_pkg;

  // default vertex capacity, range 2 to 64
  localparam int unsigned NODES_DEF = 32;

  // fixed field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned VID_W  = 5;
  localparam int unsigned VCNT_W = 6;
  // count width, holds any count up to the largest capacity of 64
  localparam int unsigned CNT_W  = 7;

  localparam logic [VCNT_W-1:0] VCNT_RST = 6'd32;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_ADD   = 2'd0;
  localparam action_t ACT_QUERY = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

endpackage

### hdl/grd_ram.sv
// ----------------------------------------------------------------------------
// grd_ram: generic simple dual-port ram
// one write port, one read port, registered read data held between reads
// ----------------------------------------------------------------------------
module grd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/grd_pick.sv
// ----------------------------------------------------------------------------
// grd_pick: neighbor pick unit
// finds the lowest set bit of the candidate vector
// ----------------------------------------------------------------------------
module grd_pick
  import grd_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic [NODES-1:0]         cand,
  output logic                     found,
  output logic [$clog2(NODES)-1:0] idx
);

  localparam int unsigned VW = $clog2(NODES);

  always_comb begin
    found = |cand;
    idx   = '0;
    for (int j = NODES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        idx = VW'(j);
      end
    end
  end

endmodule

### hdl/graph_reachability_dfs.sv
// ----------------------------------------------------------------------------
// graph_reachability_dfs: graph store with depth-first reachability search
// adjacency bit matrix in ram, explicit search stack in ram, one shared
// neighbor pick unit stepped by a small sequencer
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser: action; tdata: ids, one_way
//  out_    | out | out_tvalid/out_tready | tdata: reachable; tuser: status
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data: vertex_count
//
//  one word at a time; in_tready is high only while the sequencer is idle
//  clear, rejected and unused actions go straight to the result state; an add
//  reads, merges, writes back the first row, then the second unless one_way;
//  a query pops each vertex, checks the target and pushes unvisited neighbors
//  reset clears all edges at once through per-row valid bits, no sweep
//  a result waiting on out_tready holds the sequencer in its result state
// ----------------------------------------------------------------------------
module graph_reachability_dfs
  import grd_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // first_vertex[4:0], second_vertex[9:5],
                                        // one_way[10], zero fill
  input  logic [1:0]        in_tuser,   // action[1:0]
  // result words
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // reachable[0], zero fill
  output logic [0:0]        out_tuser,  // status[0]
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VCNT_W-1:0] cfg_data    // vertex_count
);

  localparam int unsigned VW = $clog2(NODES);
  localparam logic [NODES-1:0] ONE = NODES'(1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD_RA = 4'd1;  // read row of first vertex
  localparam logic [3:0] S_ADD_WA = 4'd2;  // merge edge bit, write back
  localparam logic [3:0] S_ADD_RB = 4'd3;  // read row of second vertex
  localparam logic [3:0] S_ADD_WB = 4'd4;  // merge reverse edge bit
  localparam logic [3:0] S_Q_INIT = 4'd5;  // push start vertex
  localparam logic [3:0] S_Q_POP  = 4'd6;  // pop top of stack
  localparam logic [3:0] S_Q_ROW  = 4'd7;  // compare with target, fetch row
  localparam logic [3:0] S_Q_SCAN = 4'd8;  // push unvisited neighbors
  localparam logic [3:0] S_RESP   = 4'd9;  // hand result to output register

  logic [3:0]        state_r, state_nxt;
  logic [VCNT_W-1:0] vcnt_r;
  logic [NODES-1:0]  row_vld_r, row_vld_nxt;
  logic [NODES-1:0]  visited_r, visited_nxt;
  logic [VW:0]       sp_r, sp_nxt;
  logic              cur_vld_r, cur_vld_nxt;
  logic [VW-1:0]     a_r, a_nxt;
  logic [VW-1:0]     b_r, b_nxt;
  logic              one_way_r, one_way_nxt;
  logic              reach_r, reach_nxt;
  logic              status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic              out_status_r, out_status_nxt;

  // ram ports
  logic              row_we, row_re;
  logic [VW-1:0]     row_waddr, row_raddr;
  logic [NODES-1:0]  row_wdata, row_rdata;
  logic              stk_we, stk_re;
  logic [VW-1:0]     stk_waddr, stk_raddr;
  logic [VW-1:0]     stk_wdata, stk_rdata;

  // pick unit
  logic [NODES-1:0]  cand;
  logic              pick_found;
  logic [VW-1:0]     pick_idx;

  // effective count and id checks
  logic [CNT_W-1:0]  n_eff;
  logic [NODES-1:0]  id_mask;
  logic              in_acc;
  logic              bad_id;
  action_t           in_act;
  logic [VID_W-1:0]  in_first, in_second;

  assign in_act    = in_tuser;
  assign in_first  = in_tdata[4:0];
  assign in_second = in_tdata[9:5];

  // count saturates at the capacity
  assign n_eff = (CNT_W'(vcnt_r) > CNT_W'(NODES)) ? CNT_W'(NODES) : CNT_W'(vcnt_r);
  assign bad_id = (CNT_W'(in_first) >= n_eff) || (CNT_W'(in_second) >= n_eff);

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      id_mask[j] = CNT_W'(j) < n_eff;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // rows never written since the last clear read as empty
  assign cand = (cur_vld_r ? row_rdata : '0) & ~visited_r & id_mask;

  grd_pick #(.NODES(NODES)) u_pick (
    .cand  (cand),
    .found (pick_found),
    .idx   (pick_idx)
  );

  grd_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  grd_ram #(.WIDTH(VW), .DEPTH(NODES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    row_vld_nxt    = row_vld_r;
    visited_nxt    = visited_r;
    sp_nxt         = sp_r;
    cur_vld_nxt    = cur_vld_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    one_way_nxt    = one_way_r;
    reach_nxt      = reach_r;
    status_nxt     = status_r;
    out_reach_nxt  = out_reach_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    row_we         = 1'b0;
    row_re         = 1'b0;
    row_waddr      = a_r;
    row_raddr      = a_r;
    row_wdata      = '0;
    stk_we         = 1'b0;
    stk_re         = 1'b0;
    stk_waddr      = sp_r[VW-1:0];
    stk_raddr      = sp_r[VW-1:0] - VW'(1);
    stk_wdata      = pick_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt       = VW'(in_first);
          b_nxt       = VW'(in_second);
          one_way_nxt = in_tdata[10];
          reach_nxt   = 1'b0;
          status_nxt  = 1'b0;
          state_nxt   = S_RESP;
          unique case (in_act)
            ACT_ADD: begin
              status_nxt = bad_id;
              if (!bad_id) begin
                state_nxt = S_ADD_RA;
              end
            end
            ACT_QUERY: begin
              status_nxt = bad_id;
              if (!bad_id) begin
                state_nxt = S_Q_INIT;
              end
            end
            ACT_CLEAR: begin
              row_vld_nxt = '0;
            end
            default: begin
              // unused code, nothing changes
            end
          endcase
        end
      end
      S_ADD_RA: begin
        row_re    = 1'b1;
        row_raddr = a_r;
        state_nxt = S_ADD_WA;
      end
      S_ADD_WA: begin
        row_we         = 1'b1;
        row_waddr      = a_r;
        row_wdata      = (row_vld_r[a_r] ? row_rdata : '0) | (ONE << b_r);
        row_vld_nxt[a_r] = 1'b1;
        state_nxt      = one_way_r ? S_RESP : S_ADD_RB;
      end
      S_ADD_RB: begin
        row_re    = 1'b1;
        row_raddr = b_r;
        state_nxt = S_ADD_WB;
      end
      S_ADD_WB: begin
        row_we         = 1'b1;
        row_waddr      = b_r;
        row_wdata      = (row_vld_r[b_r] ? row_rdata : '0) | (ONE << a_r);
        row_vld_nxt[b_r] = 1'b1;
        state_nxt      = S_RESP;
      end
      S_Q_INIT: begin
        stk_we      = 1'b1;
        stk_waddr   = '0;
        stk_wdata   = a_r;
        visited_nxt = ONE << a_r;
        sp_nxt      = (VW+1)'(1);
        state_nxt   = S_Q_POP;
      end
      S_Q_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          stk_re    = 1'b1;
          sp_nxt    = sp_r - (VW+1)'(1);
          state_nxt = S_Q_ROW;
        end
      end
      S_Q_ROW: begin
        if (stk_rdata == b_r) begin
          reach_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          row_re      = 1'b1;
          row_raddr   = stk_rdata;
          cur_vld_nxt = row_vld_r[stk_rdata];
          state_nxt   = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        // one neighbor pushed per cycle, each vertex at most once
        if (pick_found) begin
          stk_we      = 1'b1;
          visited_nxt = visited_r | (ONE << pick_idx);
          sp_nxt      = sp_r + (VW+1)'(1);
        end else begin
          state_nxt = S_Q_POP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_reach_nxt  = reach_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      vcnt_r      <= VCNT_RST;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcnt_r <= cfg_data;
      end
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    visited_r    <= visited_nxt;
    sp_r         <= sp_nxt;
    cur_vld_r    <= cur_vld_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    one_way_r    <= one_way_nxt;
    reach_r      <= reach_nxt;
    status_r     <= status_nxt;
    out_reach_r  <= out_reach_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_reach_r};
  assign out_tuser  = out_status_r;

endmodule

### sim/grd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grd_checker: result checker for the graph reachability block
// follows the graph from accepted words and the count from config writes,
// works out each input word's answer, compares it with the results in order
// ----------------------------------------------------------------------------
module grd_checker
  import grd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,   // first_vertex[4:0], second_vertex[9:5],
                                        // one_way[10], zero fill
  input  logic [1:0]        in_tuser,   // action[1:0]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,  // reachable[0], zero fill
  input  logic [0:0]        out_tuser,  // status[0]
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [VCNT_W-1:0] cfg_data,
  input  logic              run_done,
  output int unsigned       fail_count,
  output int unsigned       pending_answers
);

  localparam int unsigned NV = NODES_DEF;

  typedef struct packed {
    logic reachable;
    logic status;
  } answer_t;

  answer_t           answer_q[$];
  logic [NV-1:0]     edge_rows [NV];
  logic [VCNT_W-1:0] vertex_count;
  int unsigned       miss_total = 0;

  assign fail_count = miss_total;

  task automatic report_miss(input string what);
    if (miss_total < 40) $display("%0t grd_checker: %s", $time, what);
    miss_total++;
  endtask

  // closure of the start vertex over edges that stay below the live count
  function automatic logic reaches(input int unsigned src, input int unsigned dst,
                                   input int unsigned live);
    logic [NV-1:0] live_mask;
    logic [NV-1:0] seen;
    logic [NV-1:0] grown;
    int unsigned   v;
    live_mask = '0;
    for (v = 0; v < live; v++) live_mask[v] = 1'b1;
    grown = '0;
    grown[src] = 1'b1;
    do begin
      seen = grown;
      for (v = 0; v < NV; v++)
        if (seen[v]) grown = grown | (edge_rows[v] & live_mask);
    end while (grown != seen);
    return seen[dst];
  endfunction

  always @(posedge clk) begin : model
    answer_t     want;
    logic [4:0]  va;
    logic [4:0]  vb;
    int unsigned live;
    if (!rst_n) begin
      foreach (edge_rows[i]) edge_rows[i] = '0;
      vertex_count = VCNT_RST;
      answer_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          report_miss($sformatf("result word with nothing expected: tdata %h tuser %b",
                                out_tdata, out_tuser));
        end else begin
          want = answer_q.pop_front();
          if (out_tdata !== {7'd0, want.reachable})
            report_miss($sformatf("reachable: got tdata %h, want %0d",
                                  out_tdata, want.reachable));
          if (out_tuser[0] !== want.status)
            report_miss($sformatf("status: got %b, want %0d", out_tuser, want.status));
        end
      end

      if (cfg_valid && cfg_ready) vertex_count = cfg_data;

      if (in_tvalid && in_tready) begin
        va   = in_tdata[4:0];
        vb   = in_tdata[9:5];
        live = (vertex_count > NV) ? NV : vertex_count;
        want = '0;
        case (in_tuser)
          ACT_CLEAR: begin
            foreach (edge_rows[i]) edge_rows[i] = '0;
          end
          ACT_ADD, ACT_QUERY: begin
            if (va >= live || vb >= live) begin
              want.status = 1'b1;
            end else if (in_tuser == ACT_ADD) begin
              edge_rows[va][vb] = 1'b1;
              if (!in_tdata[10]) edge_rows[vb][va] = 1'b1;
            end else begin
              want.reachable = reaches(va, vb, live);
            end
          end
          default: ;
        endcase
        answer_q.insert(answer_q.size(), want);
      end

      if (run_done && answer_q.size() != 0) begin
        report_miss($sformatf("%0d expected result words never came", answer_q.size()));
        answer_q.delete();
      end
    end
    pending_answers <= answer_q.size();
  end

endmodule

### sim/tb_graph_reachability_dfs.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_reachability_dfs: testbench for the graph reachability block
// directed words for the corner cases, then random phases of edge adds,
// reachability queries and clears under several vertex counts, with bursty
// input, a patterned result stall and a checker that predicts every word
// ----------------------------------------------------------------------------
module tb_graph_reachability_dfs
  import grd_pkg::*;
();

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;   // first_vertex[4:0], second_vertex[9:5],
                                        // one_way[10], zero fill
  logic [1:0]        in_tuser   = '0;   // action[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;         // reachable[0], zero fill
  logic [0:0]        out_tuser;         // status[0]
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [VCNT_W-1:0] cfg_data   = '0;
  logic              run_done   = 1'b0;
  int unsigned       fail_count;
  int unsigned       pending_answers;

  // sender burst state, gap chance in percent per burst end
  int unsigned burst_left = 0;
  int unsigned gap_pct    = 30;

  // receiver stall pattern counter
  logic [9:0]  stall_cyc  = '0;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  graph_reachability_dfs #(
    .NODES(NODES_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  grd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .run_done       (run_done),
    .fail_count     (fail_count),
    .pending_answers(pending_answers)
  );

  // result stall: four modes in turn from the pattern counter, always ready,
  // coin flip, a short stall when stall_cyc[2:0] is zero, and long stalls while stall_cyc[4:0] is below 20
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1'b1;
    case (stall_cyc[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (stall_cyc[2:0] != 3'd0);
      default: out_tready <= (stall_cyc[4:0] > 5'd19);
    endcase
  end

  // hard stop well past the slowest legal run
  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

  // one input word; valid stays high into the next word unless a gap follows
  task automatic send_op(input action_t act, input logic [4:0] a, input logic [4:0] b,
                         input logic ow);
    if (burst_left == 0) begin
      if ($urandom_range(1, 100) <= gap_pct) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, ow, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off input until every result word is back
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_answers != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // vertex count write, only with the block idle
  task automatic set_vertex_count(input logic [VCNT_W-1:0] count);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned r;
    int unsigned count;
    int unsigned live;
    int unsigned span;
    int unsigned n_ops;
    action_t     act;
    logic [4:0]  a;
    logic [4:0]  b;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset count of 32
    send_op(ACT_QUERY, 5'd0, 5'd0, 1'b0);    // a vertex reaches itself, empty graph
    send_op(ACT_QUERY, 5'd0, 5'd31, 1'b0);   // no edges yet
    send_op(ACT_ADD, 5'd0, 5'd31, 1'b0);     // both directions
    send_op(ACT_QUERY, 5'd31, 5'd0, 1'b1);
    send_op(ACT_ADD, 5'd5, 5'd6, 1'b1);      // one way only
    send_op(ACT_QUERY, 5'd6, 5'd5, 1'b0);    // against the edge
    send_op(ACT_QUERY, 5'd5, 5'd6, 1'b0);
    send_op(ACT_ADD, 5'd7, 5'd7, 1'b1);      // self loop
    send_op(ACT_ADD, 5'd0, 5'd31, 1'b1);     // duplicate edge
    send_op(ACT_ADD, 5'd31, 5'd30, 1'b0);
    send_op(ACT_QUERY, 5'd0, 5'd30, 1'b0);   // two hops
    send_op(ACT_NONE, 5'd31, 5'd31, 1'b1);   // unused action, ignored
    send_op(ACT_CLEAR, 5'd31, 5'd31, 1'b1);  // fields ignored on clear
    send_op(ACT_QUERY, 5'd0, 5'd30, 1'b0);   // gone after clear

    // bad ids on either side, for add and query
    set_vertex_count(6'd5);
    send_op(ACT_ADD, 5'd5, 5'd0, 1'b0);
    send_op(ACT_ADD, 5'd0, 5'd31, 1'b1);
    send_op(ACT_QUERY, 5'd4, 5'd5, 1'b0);
    send_op(ACT_QUERY, 5'd3, 5'd3, 1'b0);

    // zero count rejects every add and query
    set_vertex_count(6'd0);
    send_op(ACT_QUERY, 5'd0, 5'd0, 1'b0);
    send_op(ACT_ADD, 5'd0, 5'd0, 1'b0);
    send_op(ACT_CLEAR, 5'd0, 5'd0, 1'b0);

    // count above capacity saturates
    set_vertex_count(6'd63);
    send_op(ACT_ADD, 5'd31, 5'd0, 1'b1);
    send_op(ACT_QUERY, 5'd31, 5'd0, 1'b0);

    // random phases, each under its own vertex count and idling mix
    for (p = 0; p < 12; p++) begin
      case (p)
        0:       count = 32;
        1:       count = 1;
        2:       count = 2;
        3:       count = 63;
        4:       count = 0;
        5:       count = 8;
        6:       count = 3;
        7:       count = 33;
        8:       count = 31;
        9:       count = 16;
        default: count = $urandom_range(1, 63);
      endcase
      set_vertex_count(count[VCNT_W-1:0]);
      gap_pct = (p % 3 == 1) ? 0 : ((p % 3 == 0) ? 25 : 70);
      live    = (count > NODES_DEF) ? NODES_DEF : count;
      n_ops   = (count == 0) ? 20 : 125;

      for (k = 0; k < n_ops; k++) begin
        r = $urandom_range(0, 99);
        if (r < 47)      act = ACT_ADD;
        else if (r < 94) act = ACT_QUERY;
        else if (r < 97) act = ACT_CLEAR;
        else             act = ACT_NONE;
        // half the words stay in a small window so paths get long and dense
        span = ($urandom_range(0, 1) == 1 || live < 10) ? live : 10;
        a = (live == 0 || $urandom_range(0, 99) < 8) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, span - 1));
        b = (live == 0 || $urandom_range(0, 99) < 8) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, span - 1));
        send_op(act, a, b, 1'($urandom_range(0, 1)));
      end
    end

    // wait out the last results, then let the checker flag any leftovers
    drain_results();
    repeat (150) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
